>>> design/dpcd_pkg.sv
// shared types and constants of the delta patch command decoder
package dpcd_pkg;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BSIZE_W  = 9;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned LEN_W    = 31;
    localparam int unsigned OFF_W    = 30;
    localparam int unsigned BLKNUM_W = 22;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned CNT_W    = 9;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_CODE  = 2'd2;

    // configuration reset values
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 9'd1;
    localparam logic [BYTE_W-1:0]  END_CODE_RST   = 8'd255;
    localparam logic [BYTE_W-1:0]  FILL_CODE_RST  = 8'd254;

    // literal opcode
    localparam logic [BYTE_W-1:0] OP_LITERAL = 8'd0;

    // command kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LITERAL = 3'd0,
        KIND_FILL    = 3'd1,
        KIND_COPY    = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_TRUNC   = 3'd4,
        KIND_BAD_OP  = 3'd5
    } kind_t;

    // one rebuild command
    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   len;
        logic [OFF_W-1:0]   off;
    } result_t;

    // configuration register set
    typedef struct packed {
        logic [BSIZE_W-1:0] block_size;
        logic [BYTE_W-1:0]  end_code;
        logic [BYTE_W-1:0]  fill_code;
    } cfg_t;

endpackage

>>> design/dpcd_if.sv
// channel interfaces: patch bytes in, commands out, configuration writes

interface dpcd_patch_if;
    logic                        valid;
    logic                        ready;
    logic [dpcd_pkg::BYTE_W-1:0] patch_byte;
    logic                        stream_end;

    modport source (output valid, output patch_byte, output stream_end, input ready);
    modport sink   (input valid, input patch_byte, input stream_end, output ready);
endinterface

interface dpcd_command_if;
    logic                        valid;
    logic                        ready;
    logic [dpcd_pkg::KIND_W-1:0] command_kind;
    logic [dpcd_pkg::BYTE_W-1:0] data_byte;
    logic [dpcd_pkg::LEN_W-1:0]  run_length;
    logic [dpcd_pkg::OFF_W-1:0]  source_offset;

    modport source (output valid, output command_kind, output data_byte,
                    output run_length, output source_offset, input ready);
    modport sink   (input valid, input command_kind, input data_byte,
                    input run_length, input source_offset, output ready);
endinterface

interface dpcd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dpcd_pkg::CFG_IDX_W-1:0] index;
    logic [dpcd_pkg::BSIZE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/dpcd_parser.sv
// patch byte parser: phase state and command formation for one byte
module dpcd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [dpcd_pkg::BYTE_W-1:0] patch_byte,
    input  logic                        stream_end,
    input  dpcd_pkg::cfg_t              cfg,
    output logic                        res_valid,
    output dpcd_pkg::result_t           res
);

    // parse phases, one-hot
    typedef enum logic [7:0] {
        PH_OPCODE    = 8'b0000_0001,
        PH_LIT_COUNT = 8'b0000_0010,
        PH_LIT_DATA  = 8'b0000_0100,
        PH_FILL_CNT  = 8'b0000_1000,
        PH_FILL_DATA = 8'b0001_0000,
        PH_COPY_WORD = 8'b0010_0000,
        PH_COPY_LEN  = 8'b0100_0000,
        PH_STOPPED   = 8'b1000_0000
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [dpcd_pkg::CNT_W-1:0]          byte_counter_reg, byte_counter_next;
    logic [dpcd_pkg::BLKNUM_W-1:0]       block_number_reg, block_number_next;
    logic [dpcd_pkg::ACC_W-1:0]          length_acc_reg, length_acc_next;
    logic [1:0]                          length_mode_reg, length_mode_next;
    logic [1:0]                          field_idx_reg, field_idx_next;

    logic [dpcd_pkg::CNT_W-1:0]          cnt_dec;
    logic [dpcd_pkg::ACC_W-1:0]          acc_new;
    logic [1:0]                          idx_inc;
    logic [1:0]                          need_idx;
    logic [dpcd_pkg::BSIZE_W-1:0]        eff_bs;
    logic [dpcd_pkg::BLKNUM_W+dpcd_pkg::BSIZE_W-1:0] product;

    // block size clamped to 1..256
    always_comb
    begin
        if (cfg.block_size == '0)
            eff_bs = 9'd1;
        else if (cfg.block_size[8])
            eff_bs = 9'd256;
        else
            eff_bs = cfg.block_size;
    end

    // copy offset multiplier
    assign product = {{dpcd_pkg::BSIZE_W{1'b0}}, block_number_reg}
                   * {{dpcd_pkg::BLKNUM_W{1'b0}}, eff_bs};

    // length byte merge
    always_comb
    begin
        acc_new = length_acc_reg;
        case (field_idx_reg)
            2'd0:    acc_new[7:0]   = patch_byte;
            2'd1:    acc_new[15:8]  = patch_byte;
            2'd2:    acc_new[23:16] = patch_byte;
            2'd3:    acc_new[31:24] = patch_byte;
            default: acc_new = length_acc_reg;
        endcase
    end

    assign idx_inc  = field_idx_reg + 2'd1;
    assign cnt_dec  = byte_counter_reg - 9'd1;

    // byte count at which the length field is complete
    always_comb
    begin
        case (length_mode_reg)
            2'd1:    need_idx = 2'd1;
            2'd2:    need_idx = 2'd2;
            default: need_idx = 2'd0;
        endcase
    end

    // next state and command for the accepted byte
    always_comb
    begin
        phase_next        = phase_reg;
        byte_counter_next = byte_counter_reg;
        block_number_next = block_number_reg;
        length_acc_next   = length_acc_reg;
        length_mode_next  = length_mode_reg;
        field_idx_next    = field_idx_reg;
        res_valid         = 1'b0;
        res.kind          = dpcd_pkg::KIND_LITERAL;
        res.data          = '0;
        res.len           = '0;
        res.off           = '0;

        if (accept && (phase_reg != PH_STOPPED))
        begin
            if (stream_end)
            begin
                phase_next = PH_STOPPED;
                res_valid  = 1'b1;
                res.kind   = dpcd_pkg::KIND_TRUNC;
            end
            else
            begin
                case (phase_reg)
                    PH_OPCODE:
                    begin
                        if (patch_byte == dpcd_pkg::OP_LITERAL)
                            phase_next = PH_LIT_COUNT;
                        else if (patch_byte == cfg.end_code)
                        begin
                            phase_next = PH_STOPPED;
                            res_valid  = 1'b1;
                            res.kind   = dpcd_pkg::KIND_DONE;
                        end
                        else if (patch_byte == cfg.fill_code)
                            phase_next = PH_FILL_CNT;
                        else
                        begin
                            block_number_next = {patch_byte[7:2], 16'd0};
                            length_mode_next  = patch_byte[1:0];
                            field_idx_next    = 2'd0;
                            length_acc_next   = '0;
                            phase_next        = PH_COPY_WORD;
                        end
                    end
                    PH_LIT_COUNT:
                    begin
                        byte_counter_next = {1'b0, patch_byte} + 9'd1;
                        phase_next        = PH_LIT_DATA;
                    end
                    PH_LIT_DATA:
                    begin
                        byte_counter_next = cnt_dec;
                        if (cnt_dec == '0)
                            phase_next = PH_OPCODE;
                        res_valid = 1'b1;
                        res.kind  = dpcd_pkg::KIND_LITERAL;
                        res.data  = patch_byte;
                        res.len   = 31'd1;
                    end
                    PH_FILL_CNT:
                    begin
                        byte_counter_next = {1'b0, patch_byte} + 9'd1;
                        phase_next        = PH_FILL_DATA;
                    end
                    PH_FILL_DATA:
                    begin
                        phase_next = PH_OPCODE;
                        res_valid  = 1'b1;
                        res.kind   = dpcd_pkg::KIND_FILL;
                        res.data   = patch_byte;
                        res.len    = {22'd0, byte_counter_reg};
                    end
                    PH_COPY_WORD:
                    begin
                        if (field_idx_reg == 2'd0)
                        begin
                            block_number_next[7:0] = patch_byte;
                            field_idx_next         = 2'd1;
                        end
                        else
                        begin
                            block_number_next[15:8] = patch_byte;
                            field_idx_next          = 2'd0;
                            if (length_mode_reg == 2'd0)
                            begin
                                phase_next = PH_STOPPED;
                                res_valid  = 1'b1;
                                res.kind   = dpcd_pkg::KIND_BAD_OP;
                            end
                            else
                                phase_next = PH_COPY_LEN;
                        end
                    end
                    PH_COPY_LEN:
                    begin
                        if (idx_inc == need_idx)
                        begin
                            field_idx_next  = 2'd0;
                            length_acc_next = acc_new;
                            phase_next      = PH_OPCODE;
                            res_valid       = 1'b1;
                            res.kind        = dpcd_pkg::KIND_COPY;
                            // negative 4-byte length copies nothing
                            if ((length_mode_reg == 2'd3) && acc_new[31])
                                res.len = '0;
                            else
                                res.len = acc_new[30:0];
                            res.off = product[dpcd_pkg::OFF_W-1:0];
                        end
                        else
                        begin
                            field_idx_next  = idx_inc;
                            length_acc_next = acc_new;
                        end
                    end
                    default:
                        phase_next = PH_STOPPED;
                endcase
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_OPCODE;
            byte_counter_reg <= '0;
            block_number_reg <= '0;
            length_acc_reg   <= '0;
            length_mode_reg  <= '0;
            field_idx_reg    <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_counter_reg <= byte_counter_next;
            block_number_reg <= block_number_next;
            length_acc_reg   <= length_acc_next;
            length_mode_reg  <= length_mode_next;
            field_idx_reg    <= field_idx_next;
        end
    end

    // stopped is terminal until reset
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STOPPED) |=> (phase_reg == PH_STOPPED))
        else $error("parser left the stopped phase");

    // a terminal command always stops the parser
    a_term_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ((res.kind == dpcd_pkg::KIND_DONE) ||
                       (res.kind == dpcd_pkg::KIND_TRUNC) ||
                       (res.kind == dpcd_pkg::KIND_BAD_OP)))
        |=> (phase_reg == PH_STOPPED))
        else $error("terminal command without stop");

    // literal data phase never runs with an empty count
    a_lit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LIT_DATA) |-> (byte_counter_reg != '0))
        else $error("literal phase with zero count");

endmodule

>>> design/dpcd_out_buf.sv
// output register with skid stage for the command channel
module dpcd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  dpcd_pkg::result_t res,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output dpcd_pkg::result_t out_res
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    dpcd_pkg::result_t out_reg;
    dpcd_pkg::result_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_ready)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    // skid only holds data behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full with empty output");

    // a drained skid refills the output register
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid drain lost a command");

    // no new command may arrive while the skid is full
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid overwritten");

endmodule

>>> design/delta_patch_command_decoder.sv
// top level of the delta patch command decoder
// output: a command formed from an accepted patch byte is registered in the output
//   register, or in the skid stage while the output register is stalled
// throughput: one patch byte per cycle; patch ready drops only while the skid
//   stage holds a command behind a stalled output register
// reset: rst_n asynchronous active low; the parser waits for an opcode and the
//   configuration returns to block size 1, end code 255, fill code 254
module delta_patch_command_decoder (
    input  logic    clk,
    input  logic    rst_n,
    dpcd_patch_if.sink     patch,
    dpcd_command_if.source command,
    dpcd_cfg_if.sink       cfg
);

    dpcd_pkg::cfg_t    cfg_reg;
    logic              patch_ready;
    logic              res_valid;
    dpcd_pkg::result_t res;
    dpcd_pkg::result_t out_res;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_size <= dpcd_pkg::BLOCK_SIZE_RST;
            cfg_reg.end_code   <= dpcd_pkg::END_CODE_RST;
            cfg_reg.fill_code  <= dpcd_pkg::FILL_CODE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dpcd_pkg::CFG_BLOCK_SIZE: cfg_reg.block_size <= cfg.data;
                dpcd_pkg::CFG_END_CODE:   cfg_reg.end_code   <= cfg.data[7:0];
                dpcd_pkg::CFG_FILL_CODE:  cfg_reg.fill_code  <= cfg.data[7:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign patch.ready = patch_ready;

    // byte parser
    dpcd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (patch.valid && patch_ready),
        .patch_byte (patch.patch_byte),
        .stream_end (patch.stream_end),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // command output buffer
    dpcd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (patch_ready),
        .out_valid (command.valid),
        .out_ready (command.ready),
        .out_res   (out_res)
    );

    assign command.command_kind  = out_res.kind;
    assign command.data_byte     = out_res.data;
    assign command.run_length    = out_res.len;
    assign command.source_offset = out_res.off;

endmodule

>>> test/tb_delta_patch_command_decoder.sv
// self-checking testbench of the delta patch command decoder
`timescale 1ns / 100ps

module tb_delta_patch_command_decoder;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;

    // opening transactions under the reset settings
    localparam logic [7:0] OPENING_BYTES [0:23] = '{
        // one literal, count and data at the extremes
        8'h00, 8'h00, 8'hFF,
        // fill of 256 zero bytes, then a single byte fill
        dpcd_pkg::FILL_CODE_RST, 8'hFF, 8'h00,
        dpcd_pkg::FILL_CODE_RST, 8'h00, 8'hFF,
        // copy from block zero, one byte length
        8'h01, 8'h00, 8'h00, 8'hFF,
        // copy from the last block, empty length
        8'hFD, 8'hFF, 8'hFF, 8'h00,
        // copy with a negative four byte length
        8'h03, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80
    };

    // parser position of the decoding model
    typedef enum logic [2:0] {
        AT_OPCODE, AT_LIT_COUNT, AT_LIT_DATA, AT_FILL_COUNT,
        AT_FILL_DATA, AT_COPY_BLOCK, AT_COPY_LENGTH, HALTED
    } parse_pos_t;

    // how the patch is closed
    typedef enum logic [1:0] {
        CLOSE_BY_END_CODE, CLOSE_BY_TRUNCATION, CLOSE_BY_BAD_OPCODE
    } patch_close_t;

    typedef struct {
        logic [7:0] value;
        logic       ended;
        bit         drain;
    } patch_item_t;

    logic clk;
    logic rst_n;

    dpcd_patch_if   patch_ch ();
    dpcd_command_if cmd_ch ();
    dpcd_cfg_if     cfg_ch ();

    delta_patch_command_decoder DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .patch   (patch_ch),
        .command (cmd_ch),
        .cfg     (cfg_ch)
    );

    patch_item_t       patch_feed [$];
    patch_item_t       next_item;
    dpcd_pkg::result_t awaited [$];
    dpcd_pkg::result_t want;
    dpcd_pkg::result_t got;
    bit                all_drained;
    bit                failed = 1'b0;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       cycle_count;

    // codes the stimulus must respect
    logic [7:0] gen_end;
    logic [7:0] gen_fill;

    // decoding model state and register copies
    parse_pos_t   parse_at;
    logic [8:0]   remaining;
    logic [21:0]  block_no;
    logic [31:0]  len_acc;
    logic [1:0]   len_mode;
    logic [1:0]   field_idx;
    logic [8:0]   sh_block;
    logic [7:0]   sh_end;
    logic [7:0]   sh_fill;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [8:0] effective_block(input logic [8:0] bs);
        if (bs == 9'd0)
            return 9'd1;
        if (bs > 9'd256)
            return 9'd256;
        return bs;
    endfunction

    // expected command for one accepted patch transaction
    function automatic bit decode_patch_byte(input logic [7:0] b, input logic ended,
                                             output dpcd_pkg::result_t cmd);
        logic [1:0]  need;
        logic [31:0] prod;
        cmd = '0;
        if (parse_at == HALTED)
            return 1'b0;
        if (ended)
        begin
            parse_at = HALTED;
            cmd.kind = dpcd_pkg::KIND_TRUNC;
            return 1'b1;
        end
        case (parse_at)
            AT_OPCODE:
            begin
                if (b == dpcd_pkg::OP_LITERAL)
                    parse_at = AT_LIT_COUNT;
                else if (b == sh_end)
                begin
                    parse_at = HALTED;
                    cmd.kind = dpcd_pkg::KIND_DONE;
                    return 1'b1;
                end
                else if (b == sh_fill)
                    parse_at = AT_FILL_COUNT;
                else
                begin
                    block_no  = {b[7:2], 16'h0000};
                    len_mode  = b[1:0];
                    field_idx = 2'd0;
                    len_acc   = '0;
                    parse_at  = AT_COPY_BLOCK;
                end
            end
            AT_LIT_COUNT, AT_FILL_COUNT:
            begin
                remaining = {1'b0, b} + 9'd1;
                parse_at  = (parse_at == AT_LIT_COUNT) ? AT_LIT_DATA : AT_FILL_DATA;
            end
            AT_LIT_DATA:
            begin
                remaining = remaining - 9'd1;
                if (remaining == 9'd0)
                    parse_at = AT_OPCODE;
                cmd.kind = dpcd_pkg::KIND_LITERAL;
                cmd.data = b;
                cmd.len  = dpcd_pkg::LEN_W'(1);
                return 1'b1;
            end
            AT_FILL_DATA:
            begin
                parse_at = AT_OPCODE;
                cmd.kind = dpcd_pkg::KIND_FILL;
                cmd.data = b;
                cmd.len  = dpcd_pkg::LEN_W'(remaining);
                return 1'b1;
            end
            AT_COPY_BLOCK:
            begin
                if (field_idx == 2'd0)
                begin
                    block_no[7:0] = b;
                    field_idx     = 2'd1;
                end
                else
                begin
                    block_no[15:8] = b;
                    field_idx      = 2'd0;
                    if (len_mode == 2'd0)
                    begin
                        parse_at = HALTED;
                        cmd.kind = dpcd_pkg::KIND_BAD_OP;
                        return 1'b1;
                    end
                    parse_at = AT_COPY_LENGTH;
                end
            end
            AT_COPY_LENGTH:
            begin
                len_acc[8 * field_idx +: 8] = b;
                field_idx = field_idx + 2'd1;
                // four byte length wraps the index back to zero
                need = (len_mode == 2'd3) ? 2'd0 : len_mode;
                if (field_idx == need)
                begin
                    field_idx = 2'd0;
                    parse_at  = AT_OPCODE;
                    prod      = 32'(block_no) * 32'(effective_block(sh_block));
                    cmd.kind  = dpcd_pkg::KIND_COPY;
                    cmd.len   = (len_mode == 2'd3 && len_acc[31]) ? '0 : len_acc[30:0];
                    cmd.off   = prod[dpcd_pkg::OFF_W-1:0];
                    return 1'b1;
                end
            end
            default:
                parse_at = HALTED;
        endcase
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            failed = 1'b1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // patch driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_ch.valid      <= 1'b0;
            patch_ch.patch_byte <= '0;
            patch_ch.stream_end <= 1'b0;
        end
        else if (!patch_ch.valid || patch_ch.ready)
        begin
            if (patch_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                !(patch_feed[0].drain && (patch_ch.valid || !all_drained)))
            begin
                next_item = patch_feed.pop_front();
                patch_ch.valid      <= 1'b1;
                patch_ch.patch_byte <= next_item.value;
                patch_ch.stream_end <= next_item.ended;
            end
            else
                patch_ch.valid <= 1'b0;
        end
    end

    // command receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_ch.ready <= 1'b0;
        else
            cmd_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: checks commands, predicts from patch transactions, tracks registers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_at  = AT_OPCODE;
            remaining = '0;
            block_no  = '0;
            len_acc   = '0;
            len_mode  = '0;
            field_idx = '0;
            sh_block  = dpcd_pkg::BLOCK_SIZE_RST;
            sh_end    = dpcd_pkg::END_CODE_RST;
            sh_fill   = dpcd_pkg::FILL_CODE_RST;
            awaited.delete();
            all_drained <= 1'b1;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                got.kind = dpcd_pkg::kind_t'(cmd_ch.command_kind);
                got.data = cmd_ch.data_byte;
                got.len  = cmd_ch.run_length;
                got.off  = cmd_ch.source_offset;
                if (awaited.size() == 0)
                begin
                    failed = 1'b1;
                    $display("%0t: unexpected command, expected none, actual kind %0d",
                             $time, got.kind);
                end
                else
                begin
                    want = awaited.pop_front();
                    check_field("command_kind", 32'(want.kind), 32'(got.kind));
                    check_field("data_byte", 32'(want.data), 32'(got.data));
                    check_field("run_length", 32'(want.len), 32'(got.len));
                    check_field("source_offset", 32'(want.off), 32'(got.off));
                end
            end
            if (patch_ch.valid && patch_ch.ready)
            begin
                if (decode_patch_byte(patch_ch.patch_byte, patch_ch.stream_end, want))
                    awaited.push_back(want);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    dpcd_pkg::CFG_BLOCK_SIZE: sh_block = cfg_ch.data;
                    dpcd_pkg::CFG_END_CODE:   sh_end   = cfg_ch.data[7:0];
                    dpcd_pkg::CFG_FILL_CODE:  sh_fill  = cfg_ch.data[7:0];
                    default:                  ;
                endcase
            end
            all_drained <= (awaited.size() == 0);
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic feed_item(input logic [7:0] value, input logic ended, input bit drain);
        patch_feed.push_back('{value, ended, drain});
    endtask

    // one well-formed command under the current codes
    function automatic void build_command(ref logic [7:0] bytes[$]);
        int unsigned pick;
        int unsigned count;
        int unsigned len_bytes;
        logic [7:0]  op;
        bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            count = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
            bytes.push_back(dpcd_pkg::OP_LITERAL);
            bytes.push_back(8'(count));
            repeat (count + 1)
                bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick < 55 && gen_fill != 8'd0 && gen_fill != gen_end)
        begin
            bytes.push_back(gen_fill);
            bytes.push_back(8'($urandom_range(0, 255)));
            bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            do
                op = 8'($urandom_range(1, 255));
            while (op[1:0] == 2'd0 || op == gen_end || op == gen_fill);
            len_bytes = (op[1:0] == 2'd1) ? 1 : (op[1:0] == 2'd2) ? 2 : 4;
            bytes.push_back(op);
            bytes.push_back(8'($urandom_range(0, 255)));
            bytes.push_back(8'($urandom_range(0, 255)));
            repeat (len_bytes)
                bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic feed_random(input int unsigned target);
        logic [7:0]  bytes[$];
        int unsigned fed;
        bit          hold;
        fed  = 0;
        hold = 1'b1;
        while (fed < target)
        begin
            build_command(bytes);
            foreach (bytes[i])
                feed_item(bytes[i], 1'b0, hold && i == 0);
            fed += bytes.size();
            hold = ($urandom_range(0, 39) == 0);
        end
    endtask

    // closes the patch one way, then sends bytes that must be ignored
    task automatic feed_closing;
        logic [7:0]   bytes[$];
        logic [7:0]   op;
        int unsigned  cut;
        patch_close_t how;
        how = patch_close_t'($urandom_range(0, 2));
        case (how)
            CLOSE_BY_END_CODE:
                feed_item(gen_end, 1'b0, 1'b0);
            CLOSE_BY_TRUNCATION:
            begin
                build_command(bytes);
                cut = $urandom_range(0, bytes.size() - 1);
                for (int i = 0; i < cut; i++)
                    feed_item(bytes[i], 1'b0, 1'b0);
                feed_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            default:
            begin
                do
                    op = {6'($urandom_range(1, 63)), 2'b00};
                while (op == gen_end || op == gen_fill);
                feed_item(op, 1'b0, 1'b0);
                feed_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                feed_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
        endcase
        repeat (20)
            feed_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic wait_for_quiet;
        do
            @(negedge clk);
        while (patch_feed.size() != 0 || patch_ch.valid || awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [dpcd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [8:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [8:0] bs, input logic [7:0] endc,
                                  input logic [7:0] fillc);
        wait_for_quiet();
        write_register(dpcd_pkg::CFG_BLOCK_SIZE, bs);
        write_register(dpcd_pkg::CFG_END_CODE, {1'b0, endc});
        write_register(dpcd_pkg::CFG_FILL_CODE, {1'b0, fillc});
        gen_end  = endc;
        gen_fill = fillc;
        @(negedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        logic [7:0] clash;
        rst_n               = 1'b0;
        patch_ch.valid      = 1'b0;
        patch_ch.patch_byte = '0;
        patch_ch.stream_end = 1'b0;
        cmd_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        send_idle_pct       = 27;
        recv_idle_pct       = 75;
        gen_end             = dpcd_pkg::END_CODE_RST;
        gen_fill            = dpcd_pkg::FILL_CODE_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: directed opening, then random commands
        foreach (OPENING_BYTES[i])
            feed_item(OPENING_BYTES[i], 1'b0, 1'b0);
        feed_random(300);

        // largest block, end code that never matches
        apply_settings(9'd256, 8'd0, 8'd255);
        feed_random(250);

        // zero block size, end and fill codes equal
        clash = 8'($urandom_range(1, 255));
        apply_settings(9'd0, clash, clash);
        send_idle_pct = 75;
        recv_idle_pct = 27;
        feed_random(250);

        // block size above range, fill code that never matches
        apply_settings(9'd511, 8'd1, 8'd0);
        feed_random(250);

        // random settings, no idling, then close the patch
        apply_settings(9'($urandom_range(1, 256)), 8'($urandom_range(1, 255)),
                       8'($urandom_range(1, 255)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        feed_random(300);
        feed_closing();
        wait_for_quiet();

        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
design/dpcd_pkg.sv
design/dpcd_if.sv
design/dpcd_parser.sv
design/dpcd_out_buf.sv
design/delta_patch_command_decoder.sv
test/tb_delta_patch_command_decoder.sv
